// File: hw/rtl/sfmr_pkg.sv
// shared types, constants and helpers for the steerable filter max response block
// no dependencies; used by the controller, the datapath and the top level

package sfmr_pkg;

  localparam int unsigned MAX_DIRECTIONS = 1024;
  localparam int unsigned SAMPLE_WIDTH   = 24;
  localparam int unsigned WEIGHT_W       = 18;
  localparam int unsigned FRAC_BITS      = 15;
  localparam int unsigned NUM_TERMS      = 6;
  localparam int unsigned ADDR_W         = $clog2(MAX_DIRECTIONS);
  localparam int unsigned CNT_W          = 11;
  localparam int unsigned OUT_W          = 32;

  // 24 x 18 signed product, pair sums, full six term sum
  localparam int unsigned PROD_W = SAMPLE_WIDTH + WEIGHT_W;
  localparam int unsigned SUM1_W = PROD_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 2;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_VOXEL = 1'b1;

  typedef logic [NUM_TERMS-1:0][SAMPLE_WIDTH-1:0] sample_vec_t;
  typedef logic [NUM_TERMS-1:0][WEIGHT_W-1:0]     weight_row_t;

  // controller to datapath
  typedef struct packed {
    logic              wr_en;
    logic              smp_en;
    logic              rd_en;
    logic              rd_first;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } dp_status_t;

  function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [SAMPLE_WIDTH-1:0] v);
    logic signed [SAMPLE_WIDTH-1:0] s;
    logic [WEIGHT_W-1:0]            r;
    s = $signed(v);
    if (s > SAMPLE_WIDTH'(WEIGHT_MAX)) begin
      r = WEIGHT_MAX;
    end else if (s < SAMPLE_WIDTH'(WEIGHT_MIN)) begin
      r = WEIGHT_MIN;
    end else begin
      r = s[WEIGHT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/steerable_filter_max_response_top.sv
// top level of the steerable filter max response block
// instantiates sfmr_ctrl and sfmr_datapath; uses sfmr_pkg
//
// Input channel (in_valid_i / in_stall_o) carries one item per transfer. With
// cmd_i at 0 the item loads the six Q3.15 weights into table entry entry_index_i
// (saturated to 18 bits); loads may arrive back to back.
// With cmd_i at 1 the item is a voxel: the six basis responses are held and the
// table is scanned from entry 0, one entry per cycle through a single read port
// of the weight memory, for n entries (direction count, clamped to 1..1024).
// The best weighted sum is rounded to basis scale and presented on the output
// channel (out_valid_o / out_stall_i) once the adder pipe has drained. The
// input stalls until the result is loaded, so no voxel overlaps the last one.
// A loaded result waits in the output register while the receiver stalls;
// further loads are taken meanwhile, but a following voxel's result is held
// back until the register frees up.
// The user must write the direction count (cfg_wr_en_i / cfg_wr_data_i) only
// while idle; unenforced. Reset sets the count to 1 and empties both channels;
// the weight table keeps no reset value and must be loaded before use.

module steerable_filter_max_response_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [sfmr_pkg::CNT_W-1:0]        cfg_wr_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [sfmr_pkg::ADDR_W-1:0]       entry_index_i,
  input  logic [sfmr_pkg::SAMPLE_WIDTH-1:0] value_0_i,
  input  logic [sfmr_pkg::SAMPLE_WIDTH-1:0] value_1_i,
  input  logic [sfmr_pkg::SAMPLE_WIDTH-1:0] value_2_i,
  input  logic [sfmr_pkg::SAMPLE_WIDTH-1:0] value_3_i,
  input  logic [sfmr_pkg::SAMPLE_WIDTH-1:0] value_4_i,
  input  logic [sfmr_pkg::SAMPLE_WIDTH-1:0] value_5_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sfmr_pkg::OUT_W-1:0]        max_response_o
);
  import sfmr_pkg::*;

  dp_cmd_t     dp_cmd;
  dp_status_t  dp_status;
  sample_vec_t values;

  assign values = {value_5_i, value_4_i, value_3_i, value_2_i, value_1_i, value_0_i};

  sfmr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dp_cmd_o      (dp_cmd),
    .dp_status_i   (dp_status)
  );

  sfmr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .dp_status_o    (dp_status),
    .entry_index_i  (entry_index_i),
    .values_i       (values),
    .max_response_o (max_response_o)
  );

endmodule

// File: hw/rtl/sfmr_ctrl.sv
// controller for the steerable filter max response block: sequences loads,
// the direction scan and the result register handshake; uses sfmr_pkg

module sfmr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_wr_en_i,
  input  logic [sfmr_pkg::CNT_W-1:0] cfg_wr_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sfmr_pkg::dp_cmd_t        dp_cmd_o,
  input  sfmr_pkg::dp_status_t     dp_status_i
);
  import sfmr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    count_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   last_q;
  logic                out_valid_q;
  logic [CNT_W-1:0]    scan_len;
  logic [ADDR_W-1:0]   last_idx;
  logic                in_xfer;
  logic                out_load;

  // zero scans one entry, anything beyond the table scans the whole table
  always_comb begin
    if (count_q == '0) begin
      scan_len = CNT_W'(1);
    end else if (count_q > CNT_W'(MAX_DIRECTIONS)) begin
      scan_len = CNT_W'(MAX_DIRECTIONS);
    end else begin
      scan_len = count_q;
    end
    last_idx = ADDR_W'(scan_len - CNT_W'(1));
  end

  assign in_xfer  = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DRAIN) && !dp_status_i.busy &&
                    (!out_valid_q || !out_stall_i);

  always_comb begin
    dp_cmd_o.wr_en    = in_xfer && (cmd_i == CMD_LOAD);
    dp_cmd_o.smp_en   = in_xfer && (cmd_i == CMD_VOXEL);
    dp_cmd_o.rd_en    = (state_q == ST_SCAN);
    dp_cmd_o.rd_first = (addr_q == '0);
    dp_cmd_o.rd_addr  = addr_q;
    dp_cmd_o.out_load = out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CNT_W'(1);
      addr_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        count_q <= cfg_wr_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (cmd_i == CMD_VOXEL)) begin
            addr_q  <= '0;
            last_q  <= last_idx;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr_q == last_q) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          // wait for the adder pipe to empty and the result register to free up
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/sfmr_datapath.sv
// datapath: direction weight memory, six-term multiply and adder pipe,
// running maximum and the rounded result register; uses sfmr_pkg

module sfmr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfmr_pkg::dp_cmd_t             dp_cmd_i,
  output sfmr_pkg::dp_status_t          dp_status_o,
  input  logic [sfmr_pkg::ADDR_W-1:0]   entry_index_i,
  input  sfmr_pkg::sample_vec_t         values_i,
  output logic [sfmr_pkg::OUT_W-1:0]    max_response_o
);
  import sfmr_pkg::*;

  localparam int unsigned PIPE_STAGES = 5;

  typedef struct packed {
    logic vld;
    logic first;
  } tag_t;

  weight_row_t               weight_mem_q [MAX_DIRECTIONS];
  weight_row_t               rdata_q;
  weight_row_t               wr_row;
  sample_vec_t               sample_q;
  tag_t                      tag_q [PIPE_STAGES];
  logic signed [PROD_W-1:0]  prod_q [NUM_TERMS];
  logic signed [SUM1_W-1:0]  sum1_q [NUM_TERMS/2];
  logic signed [ACC_W-1:0]   sum2a_q;
  logic signed [ACC_W-1:0]   sum2b_q;
  logic signed [ACC_W-1:0]   sum_q;
  logic signed [ACC_W-1:0]   best_q;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic [OUT_W-1:0]          max_response_q;
  logic                      busy;

  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      wr_row[k] = sat_weight(values_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.wr_en) begin
      weight_mem_q[entry_index_i] <= wr_row;
    end
    if (dp_cmd_i.rd_en) begin
      rdata_q <= weight_mem_q[dp_cmd_i.rd_addr];
    end
  end

  // tags follow each read down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= '{vld: dp_cmd_i.rd_en, first: dp_cmd_i.rd_first};
      for (int i = 1; i < PIPE_STAGES; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.smp_en) begin
      sample_q <= values_i;
    end
    for (int k = 0; k < NUM_TERMS; k++) begin
      prod_q[k] <= PROD_W'($signed(sample_q[k])) * PROD_W'($signed(rdata_q[k]));
    end
    for (int j = 0; j < NUM_TERMS/2; j++) begin
      sum1_q[j] <= SUM1_W'(prod_q[2*j]) + SUM1_W'(prod_q[2*j+1]);
    end
    sum2a_q <= ACC_W'(sum1_q[0]) + ACC_W'(sum1_q[1]);
    sum2b_q <= ACC_W'(sum1_q[2]);
    sum_q   <= sum2a_q + sum2b_q;
    if (tag_q[PIPE_STAGES-1].vld &&
        (tag_q[PIPE_STAGES-1].first || (sum_q > best_q))) begin
      best_q <= sum_q;
    end
    if (dp_cmd_i.out_load) begin
      max_response_q <= OUT_W'($signed(rnd_sum[ACC_W-1:FRAC_BITS]));
    end
  end

  // round half up then drop the fraction; the scaled sum always fits 32 bits
  assign rnd_sum = best_q + ACC_W'(1 << (FRAC_BITS - 1));

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < PIPE_STAGES; i++) begin
      busy = busy | tag_q[i].vld;
    end
  end

  assign dp_status_o.busy = busy;
  assign max_response_o   = max_response_q;

endmodule

// File: hw/rtl/sfmr_checker.sv
// port-level checks for the steerable filter max response block
// bound to steerable_filter_max_response_top; no package dependency

module sfmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] max_response_o
);

  // a result waiting on a stalled receiver holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(max_response_o))
    else $error("result changed or dropped while stalled");

  // a voxel transfer starts the scan
  a_voxel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i |=> in_stall_o)
    else $error("input not stalled after voxel transfer");

  // a table load never stalls the input
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !cmd_i |=> !in_stall_o)
    else $error("input stalled after load transfer");

  // a fresh result only ever follows a scan
  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a scan");

endmodule

bind steerable_filter_max_response_top sfmr_checker u_sfmr_checker (.*);
